// ===== hw/rtl/plm_pkg.sv =====
// ----------------------------------------------------------------------------
// plm_pkg
// Shared constants and types for the positional list block.
// ----------------------------------------------------------------------------
`default_nettype none

package plm_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int POS_W      = 7;
  localparam int CMP_W      = POS_W + 1;

  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // What one cell does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_LEFT  = 2'd1,
    OP_RIGHT = 2'd2,
    OP_LOAD  = 2'd3
  } cell_op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/plm_in_if.sv =====
// ----------------------------------------------------------------------------
// plm_in_if
// Command channel: valid/ready with command, position and value.
// ----------------------------------------------------------------------------
`default_nettype none

interface plm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [6:0]  position;
  logic signed [31:0] value;

  modport source (output valid, cmd, position, value, input ready);
  modport sink   (input valid, cmd, position, value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/plm_out_if.sv =====
// ----------------------------------------------------------------------------
// plm_out_if
// Result channel: valid/ready with status, data and last marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface plm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic signed [31:0] data;
  logic        last;

  modport source (output valid, status, data, last, input ready);
  modport sink   (input valid, status, data, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/plm_cell.sv =====
// ----------------------------------------------------------------------------
// plm_cell
// One list entry: holds, loads a new value or takes a neighbour's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module plm_cell (
  input  wire logic              clk,
  input  wire plm_pkg::cell_op_t op,
  input  wire plm_pkg::data_t    left,
  input  wire plm_pkg::data_t    right,
  input  wire plm_pkg::data_t    load,
  output plm_pkg::data_t         q
);

  always_ff @(posedge clk) begin
    case (op)
      plm_pkg::OP_LEFT:  q <= left;
      plm_pkg::OP_RIGHT: q <= right;
      plm_pkg::OP_LOAD:  q <= load;
      default:           q <= q;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/positional_list_insert_delete_top.sv =====
// Insert, delete and bad-position commands: the result register is loaded as the command is accepted.
// Dump: one result per cycle from the head cell while the sink takes beats,
// then the chain finishes a full rotation of CAPACITY steps before the next
// command is taken.
// The chain shifts all entries at once, so insert/delete need no shift state.
// Synchronous reset empties the list; entry contents are not cleared.
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top
// Ordered list in a chain of cells with insert, delete and dump commands.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_insert_delete_top (
  input  wire logic clk,
  input  wire logic rst,
  plm_in_if.sink    req,
  plm_out_if.source rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DUMP,
    S_ROT
  } state_t;

  state_t                       state;
  logic [plm_pkg::CNT_W-1:0]    count;
  logic [plm_pkg::IDX_W-1:0]    rot;
  logic                         ov;
  logic [1:0]                   ostatus;
  logic [31:0]                  odata;
  logic                         olast;

  plm_pkg::data_t               cell_q  [plm_pkg::CAPACITY];
  plm_pkg::cell_op_t            cell_op [plm_pkg::CAPACITY];

  logic                         ofree;
  logic                         oload;
  logic                         acc;
  logic [plm_pkg::CMP_W-1:0]    pos8;
  logic [plm_pkg::CMP_W-1:0]    cnt8;
  logic [plm_pkg::CMP_W-1:0]    pidx;
  logic                         ins_bad;
  logic                         ins_full;
  logic                         del_bad;
  logic                         dump_last;
  logic                         rot_end;
  plm_pkg::data_t               removed;
  plm_pkg::data_t               ins_val;

  assign ofree     = !ov || rsp.ready;
  assign req.ready = (state == S_IDLE) && ofree;
  assign acc       = req.valid && req.ready;

  // Result register takes a new beat this cycle
  assign oload = (acc && (req.cmd == plm_pkg::CMD_INSERT || req.cmd == plm_pkg::CMD_DELETE ||
                          (req.cmd == plm_pkg::CMD_DUMP && count == '0))) ||
                 (state == S_DUMP && ofree);

  assign pos8     = {1'b0, req.position};
  assign cnt8     = plm_pkg::CMP_W'(count);
  assign pidx     = pos8 - plm_pkg::CMP_W'(1);
  assign ins_bad  = (req.position == '0) || (pos8 > cnt8 + plm_pkg::CMP_W'(1));
  assign ins_full = (cnt8 >= plm_pkg::CMP_W'(plm_pkg::CAPACITY));
  assign del_bad  = (req.position == '0) || (pos8 > cnt8);
  assign ins_val  = plm_pkg::data_t'(req.value);

  assign dump_last = (plm_pkg::CMP_W'(rot) + plm_pkg::CMP_W'(1)) == cnt8;
  assign rot_end   = rot == plm_pkg::IDX_W'(plm_pkg::CAPACITY - 1);

  // Entry at the delete position, picked before the chain shifts down
  always_comb begin
    removed = '0;
    for (int i = 0; i < plm_pkg::CAPACITY; i++) begin
      if (plm_pkg::CMP_W'(i) == pidx) removed = removed | cell_q[i];
    end
  end

  always_comb begin
    for (int i = 0; i < plm_pkg::CAPACITY; i++) begin
      cell_op[i] = plm_pkg::OP_HOLD;
      if (acc && req.cmd == plm_pkg::CMD_INSERT && !ins_bad && !ins_full) begin
        if (plm_pkg::CMP_W'(i) == pidx)     cell_op[i] = plm_pkg::OP_LOAD;
        else if (plm_pkg::CMP_W'(i) > pidx) cell_op[i] = plm_pkg::OP_LEFT;
      end else if (acc && req.cmd == plm_pkg::CMD_DELETE && !del_bad) begin
        if (plm_pkg::CMP_W'(i) >= pidx) cell_op[i] = plm_pkg::OP_RIGHT;
      end else if ((state == S_DUMP && ofree) || state == S_ROT) begin
        // rotate toward the head; the head entry wraps round to the tail
        cell_op[i] = plm_pkg::OP_RIGHT;
      end
    end
  end

  for (genvar g = 0; g < plm_pkg::CAPACITY; g++) begin : g_cell
    plm_pkg::data_t left_d;
    plm_pkg::data_t right_d;
    if (g == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[g-1];
    end
    if (g == plm_pkg::CAPACITY - 1) begin : g_tail
      assign right_d = cell_q[0];
    end else begin : g_mid_r
      assign right_d = cell_q[g+1];
    end
    plm_cell u_cell (
      .clk   (clk),
      .op    (cell_op[g]),
      .left  (left_d),
      .right (right_d),
      .load  (ins_val),
      .q     (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rot   <= '0;
      ov    <= 1'b0;
    end else begin
      if (ov && rsp.ready && !oload) ov <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            case (req.cmd)
              plm_pkg::CMD_INSERT: begin
                ov    <= 1'b1;
                olast <= 1'b1;
                if (ins_bad) begin
                  ostatus <= plm_pkg::ST_BADPOS;
                  odata   <= '0;
                end else if (ins_full) begin
                  ostatus <= plm_pkg::ST_FULL;
                  odata   <= '0;
                end else begin
                  ostatus <= plm_pkg::ST_OK;
                  odata   <= 32'(ins_val);
                  count   <= count + plm_pkg::CNT_W'(1);
                end
              end
              plm_pkg::CMD_DELETE: begin
                ov    <= 1'b1;
                olast <= 1'b1;
                if (del_bad) begin
                  ostatus <= plm_pkg::ST_BADPOS;
                  odata   <= '0;
                end else begin
                  ostatus <= plm_pkg::ST_OK;
                  odata   <= 32'(removed);
                  count   <= count - plm_pkg::CNT_W'(1);
                end
              end
              plm_pkg::CMD_DUMP: begin
                if (count == '0) begin
                  ov      <= 1'b1;
                  olast   <= 1'b1;
                  ostatus <= plm_pkg::ST_EMPTY;
                  odata   <= '0;
                end else begin
                  rot   <= '0;
                  state <= S_DUMP;
                end
              end
              default: ;
            endcase
          end
        end
        S_DUMP: begin
          if (ofree) begin
            ov      <= 1'b1;
            ostatus <= plm_pkg::ST_OK;
            odata   <= 32'(cell_q[0]);
            olast   <= dump_last;
            rot     <= rot + plm_pkg::IDX_W'(1);
            if (dump_last) state <= rot_end ? S_IDLE : S_ROT;
          end
        end
        S_ROT: begin
          rot <= rot + plm_pkg::IDX_W'(1);
          if (rot_end) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid  = ov;
  assign rsp.status = ostatus;
  assign rsp.data   = odata;
  assign rsp.last   = olast;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    plm_pkg::CMP_W'(count) <= plm_pkg::CMP_W'(plm_pkg::CAPACITY))
    else $error("list count above capacity");

  a_count_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> (count == $past(count)))
    else $error("count moved during dump");

  a_del_dec: assert property (@(posedge clk) disable iff (rst)
    (acc && req.cmd == plm_pkg::CMD_DELETE && !del_bad)
      |=> (count == $past(count) - plm_pkg::CNT_W'(1)))
    else $error("delete did not shrink the list");

  a_dump_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROT) |-> !req.ready)
    else $error("command taken while chain still rotating");
`endif

endmodule

`default_nettype wire

// ===== sim/positional_list_insert_delete_top_tb.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_delete_top_tb
// Drives insert, delete and dump commands into the positional list and
// checks each result beat against a shadow list kept in the bench. The
// directed opening covers empty, bad position, end-of-list and extreme
// values. The random part fills the list to capacity and drains it again.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_top_tb;
  import plm_pkg::*;

  localparam int N_ITEMS        = 470;
  localparam int IDLE_PCT       = 35;
  localparam int QUIET_FROM     = 3000;
  localparam int QUIET_TO       = 6000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 2 * CAPACITY + 20;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    cmd_t             cmd;
    logic [POS_W-1:0] position;
    data_t            value;
    bit               drain_first;
  } list_cmd_t;

  typedef struct {
    status_t status;
    data_t   data;
    logic    last;
  } list_rsp_t;

  logic clk;
  logic rst;

  plm_in_if  req_ch ();
  plm_out_if rsp_ch ();

  positional_list_insert_delete_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  list_cmd_t cmd_backlog_q[$];
  list_rsp_t results_due_q[$];
  int        results_due;
  data_t     list_mem [CAPACITY];
  int        list_len;
  int        gen_len;
  int        err_count;
  int        beat_no;
  int        stall_cycles;
  int        cyc;

  // one long stretch with no idling on either side
  wire quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("mismatch: %s", msg);
  endtask

  // Shadow list: apply one accepted command and queue the beats it causes
  function automatic void apply_list_command(input list_cmd_t c);
    int    p;
    data_t removed;
    p = c.position;
    case (c.cmd)
      CMD_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          results_due_q.push_back(list_rsp_t'{ST_BADPOS, data_t'(0), 1'b1});
        end else if (list_len >= CAPACITY) begin
          results_due_q.push_back(list_rsp_t'{ST_FULL, data_t'(0), 1'b1});
        end else begin
          for (int i = list_len; i > p - 1; i--)
            list_mem[i] = list_mem[i-1];
          list_mem[p-1] = c.value;
          list_len++;
          results_due_q.push_back(list_rsp_t'{ST_OK, c.value, 1'b1});
        end
      end
      CMD_DELETE: begin
        if (p < 1 || p > list_len) begin
          results_due_q.push_back(list_rsp_t'{ST_BADPOS, data_t'(0), 1'b1});
        end else begin
          removed = list_mem[p-1];
          for (int i = p; i < list_len; i++)
            list_mem[i-1] = list_mem[i];
          list_len--;
          results_due_q.push_back(list_rsp_t'{ST_OK, removed, 1'b1});
        end
      end
      CMD_DUMP: begin
        if (list_len == 0) begin
          results_due_q.push_back(list_rsp_t'{ST_EMPTY, data_t'(0), 1'b1});
        end else begin
          for (int i = 0; i < list_len; i++)
            results_due_q.push_back(list_rsp_t'{ST_OK, list_mem[i], i == list_len - 1});
        end
      end
      default: ;
    endcase
  endfunction

  // Stimulus side only tracks the length, to aim positions at the live list
  function automatic void queue_cmd(input cmd_t op, input int pos, input data_t val,
                                    input bit drain);
    cmd_backlog_q.push_back(list_cmd_t'{op, POS_W'(pos), val, drain});
    if (op == CMD_INSERT && pos >= 1 && pos <= gen_len + 1 && gen_len < CAPACITY)
      gen_len++;
    else if (op == CMD_DELETE && pos >= 1 && pos <= gen_len)
      gen_len--;
  endfunction

  function automatic data_t pick_value();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return data_t'($urandom);
    endcase
  endfunction

  // Alternate growing and shrinking phases so the length wanders widely
  function automatic void queue_random_cmd(input int k);
    int roll;
    int ins_w;
    int pos;
    bit drain;
    roll  = $urandom_range(99);
    ins_w = ((k / 50) % 2 == 0) ? 55 : 30;
    drain = ($urandom_range(49) == 0);
    if (roll < ins_w) begin
      if ($urandom_range(9) == 0)
        pos = $urandom_range(1) ? 0 : $urandom_range(127, gen_len + 2);
      else
        pos = $urandom_range(gen_len + 1, 1);
      queue_cmd(CMD_INSERT, pos, pick_value(), drain);
    end else if (roll < 78) begin
      if (gen_len == 0 || $urandom_range(9) == 0)
        pos = $urandom_range(1) ? 0 : $urandom_range(127, gen_len + 1);
      else
        pos = $urandom_range(gen_len, 1);
      queue_cmd(CMD_DELETE, pos, pick_value(), drain);
    end else if (roll < 96) begin
      queue_cmd(CMD_DUMP, $urandom_range(127), pick_value(), drain);
    end else begin
      queue_cmd(CMD_NONE, $urandom_range(127), pick_value(), drain);
    end
  endfunction

  // Driver: present the oldest pending command, hold it until taken
  always @(posedge clk) begin : cmd_drive
    logic      slot_free;
    logic      send;
    list_cmd_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      slot_free = !req_ch.valid || req_ch.ready;
      send      = 1'b0;
      if (slot_free && cmd_backlog_q.size() != 0) begin
        if (cmd_backlog_q[0].drain_first)
          send = !req_ch.valid && results_due == 0;
        else
          send = quiet || ($urandom_range(99) >= IDLE_PCT);
      end
      if (send) begin
        nxt = cmd_backlog_q.pop_front();
        req_ch.valid    <= 1'b1;
        req_ch.cmd      <= nxt.cmd;
        req_ch.position <= nxt.position;
        req_ch.value    <= nxt.value;
      end else if (slot_free) begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: predict on accepted commands, then check the result beat
  always @(posedge clk) begin : result_check
    list_cmd_t got;
    list_rsp_t want;
    logic      moved;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      results_due  <= 0;
      stall_cycles <= 0;
      cyc          <= 0;
    end else begin
      moved = 1'b0;
      if (req_ch.valid && req_ch.ready) begin
        got.cmd         = cmd_t'(req_ch.cmd);
        got.position    = req_ch.position;
        got.value       = req_ch.value;
        got.drain_first = 1'b0;
        apply_list_command(got);
        moved = 1'b1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        moved = 1'b1;
        beat_no++;
        if (results_due_q.size() == 0) begin
          flag_error($sformatf("beat %0d arrived with nothing expected: status %0d data %h last %0b",
                               beat_no, rsp_ch.status, rsp_ch.data, rsp_ch.last));
        end else begin
          want = results_due_q.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.data !== want.data ||
              rsp_ch.last !== want.last)
            flag_error($sformatf({"beat %0d: expected status %0d data %h last %0b, ",
                                  "got status %0d data %h last %0b"},
                                 beat_no, want.status, want.data, want.last,
                                 rsp_ch.status, rsp_ch.data, rsp_ch.last));
        end
      end
      results_due  <= results_due_q.size();
      rsp_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      cyc          <= cyc + 1;
      if (moved) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("[positional_list_insert_delete_top] ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int k;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.cmd      = CMD_NONE;
    req_ch.position = '0;
    req_ch.value    = '0;
    rsp_ch.ready    = 1'b0;
    err_count       = 0;
    beat_no         = 0;
    list_len        = 0;
    gen_len         = 0;

    // empty list and bad positions
    queue_cmd(CMD_DUMP,   0, 32'h0, 1'b0);
    queue_cmd(CMD_DELETE, 1, 32'h0, 1'b0);
    queue_cmd(CMD_INSERT, 0, 32'h1234_5678, 1'b0);
    queue_cmd(CMD_INSERT, 2, 32'h1234_5678, 1'b0);
    // head, head again, tail, middle
    queue_cmd(CMD_INSERT, 1, 32'h7fff_ffff, 1'b0);
    queue_cmd(CMD_INSERT, 1, 32'h8000_0000, 1'b0);
    queue_cmd(CMD_INSERT, 3, 32'hffff_ffff, 1'b0);
    queue_cmd(CMD_INSERT, 2, 32'h0000_0000, 1'b0);
    queue_cmd(CMD_INSERT, 127, 32'h5555_aaaa, 1'b0);
    queue_cmd(CMD_DELETE, 5, 32'h0, 1'b0);
    queue_cmd(CMD_DELETE, 0, 32'h0, 1'b0);
    queue_cmd(CMD_DUMP,   0, 32'h0, 1'b0);
    queue_cmd(CMD_NONE,   127, 32'hffff_ffff, 1'b0);
    queue_cmd(CMD_DELETE, 4, 32'h0, 1'b0);
    queue_cmd(CMD_DELETE, 1, 32'h0, 1'b0);
    queue_cmd(CMD_DUMP,   127, 32'hffff_ffff, 1'b0);
    queue_cmd(CMD_DELETE, 1, 32'h0, 1'b0);
    queue_cmd(CMD_DELETE, 1, 32'h0, 1'b0);
    queue_cmd(CMD_DUMP,   0, 32'h0, 1'b1);

    for (k = 0; k < 180; k++)
      queue_random_cmd(k);

    // fill to capacity, probe the full list, then drain to empty
    while (gen_len < CAPACITY)
      queue_cmd(CMD_INSERT, $urandom_range(gen_len + 1, 1), pick_value(), 1'b0);
    queue_cmd(CMD_INSERT, CAPACITY + 1, pick_value(), 1'b0);
    queue_cmd(CMD_INSERT, CAPACITY + 2, pick_value(), 1'b0);
    queue_cmd(CMD_INSERT, 1, pick_value(), 1'b0);
    queue_cmd(CMD_DUMP,   0, pick_value(), 1'b1);
    queue_cmd(CMD_DELETE, CAPACITY, pick_value(), 1'b0);
    queue_cmd(CMD_INSERT, CAPACITY, pick_value(), 1'b0);
    queue_cmd(CMD_DELETE, CAPACITY + 1, pick_value(), 1'b0);
    while (gen_len > 0)
      queue_cmd(CMD_DELETE, $urandom_range(gen_len, 1), pick_value(), 1'b0);

    for (k = 0; cmd_backlog_q.size() < N_ITEMS; k++)
      queue_random_cmd(k);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (cmd_backlog_q.size() != 0 || req_ch.valid || results_due_q.size() != 0)
      @(negedge clk);
    // let a trailing dump rotation finish and catch any stray beat
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (results_due_q.size() != 0)
      flag_error($sformatf("%0d expected beats never arrived", results_due_q.size()));

    if (err_count == 0)
      $display("[positional_list_insert_delete_top] OK");
    else
      $display("[positional_list_insert_delete_top] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/plm_pkg.sv
hw/rtl/plm_in_if.sv
hw/rtl/plm_out_if.sv
hw/rtl/plm_cell.sv
hw/rtl/positional_list_insert_delete_top.sv
sim/positional_list_insert_delete_top_tb.sv
